// ===== rtl/hsbs_pkg.sv =====
// ----------------------------------------------------------------------------
// hsbs_pkg
// Types and constants shared by the height-map box smoother.
// ----------------------------------------------------------------------------
package hsbs_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned SUM_W      = 12;  // nine bytes at most
  localparam int unsigned SCALE_W    = 16;
  localparam int unsigned PROD_W     = SUM_W + SCALE_W;
  localparam int unsigned DIVR_W     = 12;  // 255 * 9 at most
  localparam int unsigned QUO_W      = 16;
  localparam int unsigned ROW_OUT_W  = 12;
  localparam int unsigned COL_OUT_W  = 10;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned REG_W_W    = 11;
  localparam int unsigned REG_H_W    = 13;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_SCALE = 2'd2;

  localparam logic [REG_W_W-1:0] IMAGE_WIDTH_RST  = 11'd1024;
  localparam logic [REG_H_W-1:0] IMAGE_HEIGHT_RST = 13'd1024;
  localparam logic [SCALE_W-1:0] HEIGHT_SCALE_RST = 16'd256;

  localparam logic [PIX_W-1:0] FULL_SCALE = 8'd255;

  // which sample an input releases, in emission order
  typedef enum logic [1:0] {
    EM_UP_LEFT = 2'd0,
    EM_UP      = 2'd1,
    EM_LEFT    = 2'd2,
    EM_HERE    = 2'd3
  } emit_e;

  // 3x3 window, [row][col]; row 2 / col 2 is the newest
  typedef logic [2:0][2:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic [2:0] row_mask;
    logic [2:0] col_mask;
  } nb_mask_t;

  typedef struct packed {
    logic               start;
    logic [SUM_W-1:0]   sum;
    logic [SCALE_W-1:0] scale;
    logic [DIVR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/hsbs_if.sv =====
// ----------------------------------------------------------------------------
// hsbs_if
// Valid/ready channels carrying raw height bytes in and smoothed words out.
// ----------------------------------------------------------------------------
interface hsbs_in_if;
  logic                       valid;
  logic                       ready;
  logic [hsbs_pkg::PIX_W-1:0] height_byte;

  modport source (output valid, output height_byte, input ready);
  modport sink   (input valid, input height_byte, output ready);
endinterface

interface hsbs_out_if;
  logic                           valid;
  logic                           ready;
  logic [hsbs_pkg::ROW_OUT_W-1:0] out_row;
  logic [hsbs_pkg::COL_OUT_W-1:0] out_col;
  logic [hsbs_pkg::QUO_W-1:0]     smoothed_height;
  logic                           map_done;

  modport source (output valid, output out_row, output out_col, output smoothed_height,
                  output map_done, input ready);
  modport sink   (input valid, input out_row, input out_col, input smoothed_height,
                  input map_done, output ready);
endinterface

// ===== rtl/hsbs_ram.sv =====
// ----------------------------------------------------------------------------
// hsbs_ram
// Generic single-clock RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module hsbs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/hsbs_window_sum.sv =====
// ----------------------------------------------------------------------------
// hsbs_window_sum
// Masked sum of the 3x3 window and the matching divisor 255 * count.
// ----------------------------------------------------------------------------
module hsbs_window_sum (
  input  hsbs_pkg::win_t                win_i,
  input  hsbs_pkg::nb_mask_t            mask_i,
  output logic [hsbs_pkg::SUM_W-1:0]    sum_o,
  output logic [hsbs_pkg::DIVR_W-1:0]   divisor_o
);
  import hsbs_pkg::*;

  logic [2:0][SUM_W-1:0] row_sum;
  logic [1:0]            n_rows;
  logic [1:0]            n_cols;
  logic [3:0]            count;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      row_sum[j] = '0;
      for (int m = 0; m < 3; m++) begin
        if (mask_i.row_mask[j] && mask_i.col_mask[m]) begin
          row_sum[j] = row_sum[j] + SUM_W'(win_i[j][m]);
        end
      end
    end
    sum_o     = row_sum[0] + row_sum[1] + row_sum[2];
    n_rows    = 2'($countones(mask_i.row_mask));
    n_cols    = 2'($countones(mask_i.col_mask));
    count     = 4'(n_rows) * 4'(n_cols);
    divisor_o = DIVR_W'(count) * DIVR_W'(FULL_SCALE);
  end

endmodule

// ===== rtl/hsbs_muldiv.sv =====
// ----------------------------------------------------------------------------
// hsbs_muldiv
// Shared scale unit: a multiply, then a 16-step restoring divide.
// ----------------------------------------------------------------------------
module hsbs_muldiv (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hsbs_pkg::div_req_t req_i,
  output hsbs_pkg::div_rsp_t rsp_o
);
  import hsbs_pkg::*;

  localparam int unsigned STEP_W = $clog2(QUO_W);

  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_MUL  = 3'b010,
    D_STEP = 3'b100
  } dstate_e;

  dstate_e             state_q, state_d;
  logic                done_q, done_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [SUM_W-1:0]    a_q, a_d;
  logic [SCALE_W-1:0]  b_q, b_d;
  logic [DIVR_W-1:0]   dvs_q, dvs_d;
  logic [DIVR_W-1:0]   rem_q, rem_d;
  logic [QUO_W-1:0]    acc_q, acc_d;

  logic [PROD_W-1:0]   prod;
  logic [DIVR_W:0]     rem_ext;
  logic [DIVR_W:0]     diff;
  logic                take;

  always_comb begin
    prod    = PROD_W'(a_q) * PROD_W'(b_q);
    rem_ext = {rem_q, acc_q[QUO_W-1]};
    diff    = rem_ext - {1'b0, dvs_q};
    take    = rem_ext >= {1'b0, dvs_q};

    state_d = state_q;
    done_d  = 1'b0;
    step_d  = step_q;
    a_d     = a_q;
    b_d     = b_q;
    dvs_d   = dvs_q;
    rem_d   = rem_q;
    acc_d   = acc_q;

    unique case (state_q)
      D_IDLE: begin
        if (req_i.start) begin
          a_d     = req_i.sum;
          b_d     = req_i.scale;
          dvs_d   = req_i.divisor;
          state_d = D_MUL;
        end
      end
      D_MUL: begin
        // quotient never exceeds 16 bits, so the high part starts below the divisor
        rem_d   = prod[PROD_W-1:QUO_W];
        acc_d   = prod[QUO_W-1:0];
        step_d  = '0;
        state_d = D_STEP;
      end
      D_STEP: begin
        rem_d  = take ? diff[DIVR_W-1:0] : rem_ext[DIVR_W-1:0];
        acc_d  = {acc_q[QUO_W-2:0], take};
        step_d = step_q + STEP_W'(1);
        if (step_q == '1) begin
          done_d  = 1'b1;
          state_d = D_IDLE;
        end
      end
      default: state_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      done_q  <= 1'b0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    acc_q <= acc_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = acc_q;

endmodule

// ===== rtl/heightmap_scale_box_smooth_core.sv =====
// ----------------------------------------------------------------------------
// heightmap_scale_box_smooth_core
// Streaming 3x3 edge-normalised box smoother for an 8-bit height map.
// ----------------------------------------------------------------------------
// Raw height bytes enter on in_if in raster order; smoothed words leave on
// out_if tagged with row and column, map_done set on the last sample of a map.
// Each output is floor(sum * height_scale / (255 * count)) over the in-bounds
// 3x3 neighbourhood, emitted once its lower and right neighbours are in.
// One input releases zero to four words.
// Configuration (image width, height, scale) must be written by the user via
// cfg_we_i / cfg_idx_i / cfg_data_i only while the block is idle; the block
// itself does not enforce this. A write to a known register restarts the map.
// An input is accepted with a line store read, then stored and shifted into
// the window; each word it releases is issued to the shared multiply/divide
// unit (a multiply, then 16 restoring divide steps) and handed off.
// in_if.ready is high only while no input is in flight.
// A finished word sits in the output register; if the receiver stalls, the
// next word waits in the divider and the sequencer holds until the register
// frees. Reset clears counters, sequencer and output valid; registers return
// to width 1024, height 1024, scale 256. The line stores need no clearing.
// ----------------------------------------------------------------------------
module heightmap_scale_box_smooth_core #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [hsbs_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [hsbs_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  hsbs_in_if.sink                           in_if,
  hsbs_out_if.source                        out_if
);
  import hsbs_pkg::*;

  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOAD  = 5'b00010,
    S_START = 5'b00100,
    S_WAIT  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_e;

  state_e              state_q, state_d;

  logic [REG_W_W-1:0]  reg_w_q, reg_w_d;
  logic [REG_H_W-1:0]  reg_h_q, reg_h_d;
  logic [SCALE_W-1:0]  scale_q, scale_d;
  logic                cfg_hit;

  logic [CW-1:0]       col_q, col_d;
  logic [RW-1:0]       row_q, row_d;

  logic [PIX_W-1:0]    px_q, px_d;
  logic [CW-1:0]       c_q, c_d;
  logic [RW-1:0]       r_q, r_d;
  logic                r_ge1_q, r_ge1_d, r_ge2_q, r_ge2_d;
  logic                c_ge1_q, c_ge1_d, c_ge2_q, c_ge2_d;
  logic [3:0]          pend_q, pend_d;
  win_t                win_q, win_d;

  logic                   out_valid_q, out_valid_d;
  logic [ROW_OUT_W-1:0]   out_row_q, out_row_d;
  logic [COL_OUT_W-1:0]   out_col_q, out_col_d;
  logic [QUO_W-1:0]       out_val_q, out_val_d;
  logic                   out_done_q, out_done_d;

  logic [31:0]         w_eff, h_eff;
  logic [CW-1:0]       last_col;
  logic [RW-1:0]       last_row;
  logic [CW-1:0]       cur_c;
  logic [RW-1:0]       cur_r;
  logic                wrap, last_c, last_r, accept, out_free;

  emit_e               sel;
  logic                up, left;
  nb_mask_t            mask;
  logic [SUM_W-1:0]    nb_sum;
  logic [DIVR_W-1:0]   nb_divisor;
  div_req_t            div_req;
  div_rsp_t            div_rsp;
  logic [RW-1:0]       orow;
  logic [CW-1:0]       ocol;

  logic                ram_re, ram_we;
  logic [PIX_W-1:0]    b0_rdata, b1_rdata;

  // effective dimensions: zero acts as one, oversize clamps to the maximum
  always_comb begin
    w_eff = 32'(reg_w_q);
    if (w_eff == 32'd0) w_eff = 32'd1;
    if (w_eff > MAX_WIDTH) w_eff = MAX_WIDTH;
    h_eff = 32'(reg_h_q);
    if (h_eff == 32'd0) h_eff = 32'd1;
    if (h_eff > MAX_HEIGHT) h_eff = MAX_HEIGHT;
    last_col = CW'(w_eff - 32'd1);
    last_row = RW'(h_eff - 32'd1);
  end

  always_comb begin
    wrap   = (col_q > last_col) || (row_q > last_row);
    cur_c  = wrap ? '0 : col_q;
    cur_r  = wrap ? '0 : row_q;
    last_c = (cur_c == last_col);
    last_r = (cur_r == last_row);
    accept = in_if.valid && in_if.ready;
  end

  // lowest pending word goes first, which is raster order
  always_comb begin
    if (pend_q[EM_UP_LEFT])   sel = EM_UP_LEFT;
    else if (pend_q[EM_UP])   sel = EM_UP;
    else if (pend_q[EM_LEFT]) sel = EM_LEFT;
    else                      sel = EM_HERE;
    up            = (sel == EM_UP_LEFT) || (sel == EM_UP);
    left          = (sel == EM_UP_LEFT) || (sel == EM_LEFT);
    mask.row_mask = up   ? {1'b1, r_ge1_q, r_ge2_q} : {1'b1, r_ge1_q, 1'b0};
    mask.col_mask = left ? {1'b1, c_ge1_q, c_ge2_q} : {1'b1, c_ge1_q, 1'b0};
    orow          = up   ? (r_q - RW'(1)) : r_q;
    ocol          = left ? (c_q - CW'(1)) : c_q;
  end

  hsbs_window_sum u_window_sum (
    .win_i     (win_q),
    .mask_i    (mask),
    .sum_o     (nb_sum),
    .divisor_o (nb_divisor)
  );

  always_comb begin
    div_req.start   = (state_q == S_START);
    div_req.sum     = nb_sum;
    div_req.scale   = scale_q;
    div_req.divisor = nb_divisor;
  end

  hsbs_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // bank 0 holds row r-2, bank 1 row r-1
  assign ram_re = accept;
  assign ram_we = (state_q == S_LOAD);

  hsbs_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line0 (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (c_q),
    .wdata_i (b1_rdata),
    .re_i    (ram_re),
    .raddr_i (cur_c),
    .rdata_o (b0_rdata)
  );

  hsbs_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line1 (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (c_q),
    .wdata_i (px_q),
    .re_i    (ram_re),
    .raddr_i (cur_c),
    .rdata_o (b1_rdata)
  );

  // configuration decode
  always_comb begin
    reg_w_d = reg_w_q;
    reg_h_d = reg_h_q;
    scale_d = scale_q;
    cfg_hit = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IMAGE_WIDTH: begin
          reg_w_d = cfg_data_i[REG_W_W-1:0];
          cfg_hit = 1'b1;
        end
        CFG_IMAGE_HEIGHT: begin
          reg_h_d = cfg_data_i[REG_H_W-1:0];
          cfg_hit = 1'b1;
        end
        CFG_HEIGHT_SCALE: begin
          scale_d = cfg_data_i;
          cfg_hit = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    row_d       = row_q;
    px_d        = px_q;
    c_d         = c_q;
    r_d         = r_q;
    r_ge1_d     = r_ge1_q;
    r_ge2_d     = r_ge2_q;
    c_ge1_d     = c_ge1_q;
    c_ge2_d     = c_ge2_q;
    pend_d      = pend_q;
    win_d       = win_q;
    out_valid_d = out_valid_q;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_val_d   = out_val_q;
    out_done_d  = out_done_q;
    out_free    = !out_valid_q || out_if.ready;

    if (out_valid_q && out_if.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          px_d    = in_if.height_byte;
          c_d     = cur_c;
          r_d     = cur_r;
          r_ge1_d = (32'(cur_r) >= 32'd1);
          r_ge2_d = (32'(cur_r) >= 32'd2);
          c_ge1_d = (32'(cur_c) >= 32'd1);
          c_ge2_d = (32'(cur_c) >= 32'd2);
          pend_d[EM_UP_LEFT] = r_ge1_d && c_ge1_d;
          pend_d[EM_UP]      = r_ge1_d && last_c;
          pend_d[EM_LEFT]    = last_r && c_ge1_d;
          pend_d[EM_HERE]    = last_r && last_c;
          if (last_c) begin
            col_d = '0;
            row_d = last_r ? '0 : (cur_r + RW'(1));
          end else begin
            col_d = cur_c + CW'(1);
          end
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        for (int j = 0; j < 3; j++) begin
          win_d[j][0] = win_q[j][1];
          win_d[j][1] = win_q[j][2];
        end
        win_d[0][2] = b0_rdata;
        win_d[1][2] = b1_rdata;
        win_d[2][2] = px_q;
        state_d     = (pend_q != 4'b0) ? S_START : S_IDLE;
      end
      S_START: begin
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (div_rsp.done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_row_d    = ROW_OUT_W'(orow);
          out_col_d    = COL_OUT_W'(ocol);
          out_val_d    = div_rsp.quotient;
          out_done_d   = (sel == EM_HERE);
          pend_d[sel]  = 1'b0;
          state_d      = (pend_d != 4'b0) ? S_START : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_hit) begin
      col_d = '0;
      row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      reg_w_q     <= IMAGE_WIDTH_RST;
      reg_h_q     <= IMAGE_HEIGHT_RST;
      scale_q     <= HEIGHT_SCALE_RST;
      col_q       <= '0;
      row_q       <= '0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      reg_w_q     <= reg_w_d;
      reg_h_q     <= reg_h_d;
      scale_q     <= scale_d;
      col_q       <= col_d;
      row_q       <= row_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q       <= px_d;
    c_q        <= c_d;
    r_q        <= r_d;
    r_ge1_q    <= r_ge1_d;
    r_ge2_q    <= r_ge2_d;
    c_ge1_q    <= c_ge1_d;
    c_ge2_q    <= c_ge2_d;
    win_q      <= win_d;
    out_row_q  <= out_row_d;
    out_col_q  <= out_col_d;
    out_val_q  <= out_val_d;
    out_done_q <= out_done_d;
  end

  assign in_if.ready            = (state_q == S_IDLE);
  assign out_if.valid           = out_valid_q;
  assign out_if.out_row         = out_row_q;
  assign out_if.out_col         = out_col_q;
  assign out_if.smoothed_height = out_val_q;
  assign out_if.map_done        = out_done_q;

endmodule

// ===== rtl/hsbs_checker.sv =====
// ----------------------------------------------------------------------------
// hsbs_checker
// Port-level checks on the smoother's channels, bound to the top level.
// ----------------------------------------------------------------------------
module hsbs_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [hsbs_pkg::ROW_OUT_W-1:0] out_row_i,
  input logic [hsbs_pkg::COL_OUT_W-1:0] out_col_i,
  input logic [hsbs_pkg::QUO_W-1:0]     smoothed_height_i,
  input logic                           map_done_i
);

  // a stalled word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_row_i) && $stable(out_col_i)
      && $stable(smoothed_height_i) && $stable(map_done_i))
    else $error("stalled output word changed");

  // one input at a time: busy straight after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken again while an item is in flight");

  // words are only produced while an item is being worked on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("output word appeared with no item in flight");

endmodule

bind heightmap_scale_box_smooth_core hsbs_checker u_hsbs_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_if.valid),
  .in_ready_i        (in_if.ready),
  .out_valid_i       (out_if.valid),
  .out_ready_i       (out_if.ready),
  .out_row_i         (out_if.out_row),
  .out_col_i         (out_if.out_col),
  .smoothed_height_i (out_if.smoothed_height),
  .map_done_i        (out_if.map_done)
);

// ===== tb/hsbs_smooth_checker.sv =====
// ----------------------------------------------------------------------------
// hsbs_smooth_checker
// Watches the configuration port and both channels of the height-map box
// smoother. Every accepted height byte is run through a local copy of the line
// stores and window, and the smoothed words it releases are queued; every
// accepted output word is compared field by field with the oldest one queued.
// ----------------------------------------------------------------------------
module hsbs_smooth_checker
  import hsbs_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  hsbs_in_if                    in_mon,
  hsbs_out_if                   out_mon,
  output int unsigned           fail_cnt_o,
  output int unsigned           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ROW_OUT_W-1:0] row;
    logic [COL_OUT_W-1:0] col;
    logic [QUO_W-1:0]     height;
    logic                 done;
  } smooth_word_t;

  smooth_word_t       smoothed_due [$];
  smooth_word_t       head_word;
  logic [REG_W_W-1:0] map_width;
  logic [REG_H_W-1:0] map_height;
  logic [SCALE_W-1:0] map_scale;
  logic [PIX_W-1:0]   line_buf [2][MAX_WIDTH];  // [0] row r-2, [1] row r-1
  logic [PIX_W-1:0]   win_buf [3][2];           // columns c-2 and c-1
  logic [PIX_W-1:0]   nbhd [3][3];              // rows r-2..r, columns c-2..c
  int                 at_row;
  int                 at_col;
  int unsigned        fails = 0;

  function automatic int clamp_dim(int raw, int top);
    if (raw == 0) return 1;
    if (raw > top) return top;
    return raw;
  endfunction

  // mean of the in-bounds part of the 3x3 around (orow, ocol), scaled by
  // map_scale/255 and truncated
  function automatic void queue_smoothed(int r, int c, int orow, int ocol,
                                         int h, int w, bit done);
    int                nr;
    int                nc;
    int                wr;
    int                wc;
    int unsigned       cnt;
    longint unsigned   acc;
    longint unsigned   quo;
    smooth_word_t      word;
    acc = 0;
    cnt = 0;
    for (nr = orow - 1; nr <= orow + 1; nr++) begin
      for (nc = ocol - 1; nc <= ocol + 1; nc++) begin
        wr = nr - (r - 2);
        wc = nc - (c - 2);
        if (nr < 0 || nr >= h || nc < 0 || nc >= w) continue;
        if (wr < 0 || wr > 2 || wc < 0 || wc > 2) continue;
        acc += nbhd[wr][wc];
        cnt++;
      end
    end
    quo = 0;
    if (cnt != 0) begin
      acc = acc * map_scale;
      quo = acc / (longint'(FULL_SCALE) * cnt);
    end
    word.row    = orow[ROW_OUT_W-1:0];
    word.col    = ocol[COL_OUT_W-1:0];
    word.height = quo[QUO_W-1:0];
    word.done   = done;
    smoothed_due.push_back(word);
  endfunction

  function automatic void take_height_byte(logic [PIX_W-1:0] px);
    int w;
    int h;
    int r;
    int c;
    bit last_c;
    bit last_r;
    w = clamp_dim(int'(map_width), MAX_WIDTH);
    h = clamp_dim(int'(map_height), MAX_HEIGHT);
    if (at_col >= w || at_row >= h) begin
      at_row = 0;
      at_col = 0;
    end
    r = at_row;
    c = at_col;
    last_c = (c == w - 1);
    last_r = (r == h - 1);
    foreach (win_buf[k]) begin
      nbhd[k][0] = win_buf[k][0];
      nbhd[k][1] = win_buf[k][1];
    end
    nbhd[0][2] = line_buf[0][c];
    nbhd[1][2] = line_buf[1][c];
    nbhd[2][2] = px;
    line_buf[0][c] = nbhd[1][2];
    line_buf[1][c] = px;
    foreach (win_buf[k]) begin
      win_buf[k][0] = nbhd[k][1];
      win_buf[k][1] = nbhd[k][2];
    end
    // release order: up-left, up (last column), left (last row), here (corner)
    if (r >= 1 && c >= 1) queue_smoothed(r, c, r - 1, c - 1, h, w, 1'b0);
    if (r >= 1 && last_c) queue_smoothed(r, c, r - 1, c, h, w, 1'b0);
    if (last_r && c >= 1) queue_smoothed(r, c, r, c - 1, h, w, 1'b0);
    if (last_r && last_c) queue_smoothed(r, c, r, c, h, w, 1'b1);
    if (last_c) begin
      at_col = 0;
      at_row = last_r ? 0 : r + 1;
    end else begin
      at_col = c + 1;
    end
  endfunction

  function automatic void check_field(string name, logic [QUO_W-1:0] want,
                                      logic [QUO_W-1:0] got);
    if (got !== want) begin
      fails++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smoothed_due.delete();
      map_width  = IMAGE_WIDTH_RST;
      map_height = IMAGE_HEIGHT_RST;
      map_scale  = HEIGHT_SCALE_RST;
      at_row = 0;
      at_col = 0;
      foreach (line_buf[i, j]) line_buf[i][j] = '0;
      foreach (win_buf[i, j]) win_buf[i][j] = '0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (smoothed_due.size() == 0) begin
          fails++;
          $error("word at row %0d col %0d with nothing expected",
                 out_mon.out_row, out_mon.out_col);
        end else begin
          head_word = smoothed_due.pop_front();
          check_field("out_row", QUO_W'(head_word.row), QUO_W'(out_mon.out_row));
          check_field("out_col", QUO_W'(head_word.col), QUO_W'(out_mon.out_col));
          check_field("smoothed_height", head_word.height, out_mon.smoothed_height);
          check_field("map_done", QUO_W'(head_word.done), QUO_W'(out_mon.map_done));
        end
      end
      if (cfg_we_i) begin
        // any known register restarts the map
        case (cfg_idx_i)
          CFG_IMAGE_WIDTH: begin
            map_width = cfg_data_i[REG_W_W-1:0];
            at_row = 0;
            at_col = 0;
          end
          CFG_IMAGE_HEIGHT: begin
            map_height = cfg_data_i[REG_H_W-1:0];
            at_row = 0;
            at_col = 0;
          end
          CFG_HEIGHT_SCALE: begin
            map_scale = cfg_data_i[SCALE_W-1:0];
            at_row = 0;
            at_col = 0;
          end
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) take_height_byte(in_mon.height_byte);
    end
    fail_cnt_o = fails;
    pending_o  = smoothed_due.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the height-map box smoother: a short directed set of small
// maps (corners, edges, one-row and one-column maps, clamped sizes, scale
// extremes), then random maps under three idling patterns, a long receiver
// hold-off and short runs on clamped map sizes. Checking is left to
// hsbs_smooth_checker.
// ----------------------------------------------------------------------------
module tb_top
  import hsbs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          MAX_WIDTH      = 1024;
  localparam int          MAX_HEIGHT     = 4096;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned TAIL_CYCLES    = 100;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned RANDOM_ITEMS   = 40;
  localparam int unsigned CLAMP_ITEMS    = 20;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int unsigned           send_idle_pct;
  int unsigned           recv_idle_pct;
  int unsigned           fail_cnt;
  int unsigned           words_due;
  int unsigned           quiet_cycles = 0;
  bit                    hold_req = 1'b0;
  bit                    hold_taken = 1'b0;

  hsbs_in_if  raw_ch ();
  hsbs_out_if smooth_ch ();

  heightmap_scale_box_smooth_core #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_if      (raw_ch),
    .out_if     (smooth_ch)
  );

  hsbs_smooth_checker #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_mon     (raw_ch),
    .out_mon    (smooth_ch),
    .fail_cnt_o (fail_cnt),
    .pending_o  (words_due)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    smooth_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        smooth_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      smooth_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (raw_ch.valid && raw_ch.ready) || (smooth_ch.valid && smooth_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // called and left at a falling edge; valid stays high into the next word
  task automatic send_height(input logic [PIX_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      raw_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    raw_ch.valid       <= 1'b1;
    raw_ch.height_byte <= b;
    do @(posedge clk_i); while (!raw_ch.ready);
    @(negedge clk_i);
  endtask

  // drain, let the last word-less byte clear, then write all three registers
  task automatic set_map(input int unsigned w, input int unsigned h, input int unsigned s);
    raw_ch.valid <= 1'b0;
    while (words_due != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    while (!raw_ch.ready) @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_IMAGE_WIDTH;
    cfg_data <= CFG_DATA_W'(w);
    @(negedge clk_i);
    cfg_idx  <= CFG_IMAGE_HEIGHT;
    cfg_data <= CFG_DATA_W'(h);
    @(negedge clk_i);
    cfg_idx  <= CFG_HEIGHT_SCALE;
    cfg_data <= CFG_DATA_W'(s);
    @(negedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  // mostly whole maps (sometimes two back to back), some cut short by the
  // next configuration
  task automatic random_maps(input int unsigned budget);
    int unsigned sent;
    int unsigned w;
    int unsigned h;
    int unsigned s;
    int unsigned full;
    int unsigned n;
    int unsigned style;
    sent = 0;
    while (sent < budget) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(7, 14) : $urandom_range(0, 6);
      h = ($urandom_range(9) == 0) ? $urandom_range(MAX_HEIGHT + 1, 8191) : $urandom_range(0, 7);
      case ($urandom_range(5))
        0: s = 0;
        1: s = 65535;
        2: s = 255;
        default: s = $urandom_range(65535);
      endcase
      full = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : ((h > MAX_HEIGHT) ? MAX_HEIGHT : h));
      if (full > 48 || $urandom_range(3) == 0) n = $urandom_range(1, 24);
      else n = ($urandom_range(2) == 0) ? 2 * full : full;
      style = $urandom_range(7);
      set_map(w, h, s);
      repeat (n) begin
        send_height((style == 0) ? 8'hFF : (style == 1) ? 8'h00 : PIX_W'($urandom));
      end
      sent += n;
    end
  endtask

  initial begin
    int unsigned i;
    rst_ni             = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = CFG_IMAGE_WIDTH;
    cfg_data           = '0;
    raw_ch.valid       = 1'b0;
    raw_ch.height_byte = '0;
    send_idle_pct      = 22;
    recv_idle_pct      = 82;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset geometry: top row of a wide map, nothing comes out
    repeat (3) send_height(PIX_W'($urandom));

    // 3x3 with a dip in the centre: corners, edges, centre, full scale
    set_map(3, 3, 65535);
    for (i = 0; i < 9; i++) send_height((i == 4) ? 8'h00 : 8'hFF);
    // zero width acts as one column
    set_map(0, 3, 255);
    for (i = 0; i < 3; i++) send_height(PIX_W'(i * 100 + 7));
    // zero height acts as one row, zero scale
    set_map(4, 0, 0);
    repeat (4) send_height(8'hFF);
    // single sample map, run twice to wrap into a fresh map
    set_map(1, 1, 65535);
    send_height(8'hFF);
    send_height(8'h80);
    set_map(2, 2, 1);
    repeat (8) send_height(PIX_W'($urandom));

    random_maps(RANDOM_ITEMS);
    send_idle_pct = 82;
    recv_idle_pct = 22;
    random_maps(RANDOM_ITEMS);
    send_idle_pct = 0;
    recv_idle_pct = 0;

    // long receiver hold-off while bytes keep coming: the block backs up
    set_map(5, 5, $urandom_range(65535));
    hold_req = 1'b1;
    repeat (25) send_height(PIX_W'($urandom));
    random_maps(RANDOM_ITEMS);

    // oversized registers clamp: a one-row map as wide as allowed, then a
    // one-column map as tall as allowed
    set_map(2047, 1, $urandom_range(65535));
    repeat (CLAMP_ITEMS) send_height(PIX_W'($urandom));
    set_map(1, 8191, 65535);
    repeat (CLAMP_ITEMS) send_height(PIX_W'($urandom));

    raw_ch.valid <= 1'b0;
    while (words_due != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (fail_cnt == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== heightmap_scale_box_smooth_core.f =====
rtl/hsbs_pkg.sv
rtl/hsbs_if.sv
rtl/hsbs_ram.sv
rtl/hsbs_window_sum.sv
rtl/hsbs_muldiv.sv
rtl/heightmap_scale_box_smooth_core.sv
rtl/hsbs_checker.sv
tb/hsbs_smooth_checker.sv
tb/tb_top.sv
